FILE: rtl/vrd_pkg.sv
`timescale 1ns / 1ps

package vrd_pkg;

  // Default string capacity of the decoder (text bytes per record)
  localparam int STRING_CAPACITY_DEF = 64;

  // Result queue depth; must stay a power of two, at least 2
  localparam int OUT_DEPTH = 4;

  // Record layout
  localparam logic [7:0] REC_VERSION = 8'd1;
  localparam logic [7:0] VER_POS     = 8'd3;
  localparam logic [7:0] TYPE_POS    = 8'd4;
  localparam logic [7:0] PAY_START   = 8'd8;
  localparam logic [7:0] HDR_BYTES   = 8'd16;
  localparam logic [7:0] IMAG_END    = 8'd24;
  localparam logic [7:0] IDX_MAX     = 8'd255;

  // Type codes
  localparam logic [7:0] T_EMPTY   = 8'd0;
  localparam logic [7:0] T_INT     = 8'd1;
  localparam logic [7:0] T_FLOAT   = 8'd2;
  localparam logic [7:0] T_COMPLEX = 8'd3;
  localparam logic [7:0] T_STRING  = 8'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_NO_IMAG   = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_OVERRUN   = 3'd6
  } status_e;

  typedef struct packed {
    logic        is_final;
    status_e     status;
    logic [7:0]  value_type;
    logic [63:0] payload;
    logic [63:0] imag_bits;
    logic [7:0]  text_byte;
    logic [5:0]  text_length;
  } result_t;

  // Up to two results per byte: a text byte, then the summary
  typedef struct packed {
    logic    text_vld;
    logic    sum_vld;
    result_t text;
    result_t summary;
  } push_t;

  // Expected magic byte at header offsets 0..2
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'h51;  // 'Q'
      2'd1:    m = 8'h44;  // 'D'
      2'd2:    m = 8'h53;  // 'S'
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/vrd_tracker.sv
`timescale 1ns / 1ps

module vrd_tracker #(
  parameter int STRING_CAPACITY = vrd_pkg::STRING_CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output vrd_pkg::push_t push_o
);
  import vrd_pkg::*;

  logic [7:0]  byte_index_q, byte_index_d, idx_inc, idx_off, need_len;
  logic        header_good_q, header_good_d, hg_upd;
  logic [7:0]  type_q, type_d, type_upd;
  logic [63:0] pay_q, pay_d, pay_upd;
  logic [63:0] imag_q, imag_d, imag_upd;
  status_e     st;
  logic [63:0] sum_pay, sum_imag;
  logic [5:0]  sum_tl;

  always_comb begin
    hg_upd   = header_good_q;
    type_upd = type_q;
    pay_upd  = pay_q;
    imag_upd = imag_q;
    if (byte_index_q < VER_POS) begin
      if (byte_i != magic_byte(byte_index_q[1:0])) hg_upd = 1'b0;
    end else if (byte_index_q == VER_POS) begin
      if (byte_i != REC_VERSION) hg_upd = 1'b0;
    end else if (byte_index_q == TYPE_POS) begin
      type_upd = byte_i;
    end else if (byte_index_q >= PAY_START && byte_index_q < HDR_BYTES) begin
      pay_upd[{byte_index_q[2:0], 3'b000} +: 8] = byte_i;
    end else if (byte_index_q >= HDR_BYTES && byte_index_q < IMAG_END) begin
      imag_upd[{byte_index_q[2:0], 3'b000} +: 8] = byte_i;
    end

    idx_inc  = (byte_index_q == IDX_MAX) ? byte_index_q : byte_index_q + 8'd1;
    idx_off  = byte_index_q - HDR_BYTES;
    // only meaningful once the length is known to be below capacity
    need_len = HDR_BYTES + {2'b00, pay_upd[5:0]};

    // Summary status, in check order
    st       = ST_OK;
    sum_pay  = '0;
    sum_imag = '0;
    sum_tl   = '0;
    if (idx_inc < HDR_BYTES) begin
      st = ST_SHORT;
    end else if (!hg_upd) begin
      st = ST_BAD_HDR;
    end else if (type_upd == T_EMPTY) begin
      st = ST_OK;
    end else if (type_upd == T_INT || type_upd == T_FLOAT) begin
      sum_pay = pay_upd;
    end else if (type_upd == T_COMPLEX) begin
      if (idx_inc < IMAG_END) begin
        st = ST_NO_IMAG;
      end else begin
        sum_pay  = pay_upd;
        sum_imag = imag_upd;
      end
    end else if (type_upd == T_STRING) begin
      if (pay_upd >= 64'(STRING_CAPACITY)) begin
        st = ST_TOO_LONG;
      end else if (idx_inc < need_len) begin
        st = ST_OVERRUN;
      end else begin
        sum_pay = pay_upd;
        sum_tl  = pay_upd[5:0];
      end
    end else begin
      st = ST_BAD_TYPE;
    end

    // Text bytes lie at offset 16 and up, so the header state is already final
    push_o.text_vld = fire_i && header_good_q && (type_q == T_STRING) &&
                      (byte_index_q >= HDR_BYTES) &&
                      (pay_q < 64'(STRING_CAPACITY)) &&
                      ({56'd0, idx_off} < pay_q);
    push_o.text             = '0;
    push_o.text.status      = ST_OK;
    push_o.text.text_byte   = byte_i;

    push_o.sum_vld              = fire_i && last_i;
    push_o.summary.is_final     = 1'b1;
    push_o.summary.status       = st;
    push_o.summary.value_type   = type_upd;
    push_o.summary.payload      = sum_pay;
    push_o.summary.imag_bits    = sum_imag;
    push_o.summary.text_byte    = 8'd0;
    push_o.summary.text_length  = sum_tl;

    byte_index_d  = byte_index_q;
    header_good_d = header_good_q;
    type_d        = type_q;
    pay_d         = pay_q;
    imag_d        = imag_q;
    if (fire_i) begin
      if (last_i) begin
        byte_index_d  = '0;
        header_good_d = 1'b1;
        type_d        = '0;
        pay_d         = '0;
        imag_d        = '0;
      end else begin
        byte_index_d  = idx_inc;
        header_good_d = hg_upd;
        type_d        = type_upd;
        pay_d         = pay_upd;
        imag_d        = imag_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= '0;
      header_good_q <= 1'b1;
      type_q        <= '0;
      pay_q         <= '0;
      imag_q        <= '0;
    end else begin
      byte_index_q  <= byte_index_d;
      header_good_q <= header_good_d;
      type_q        <= type_d;
      pay_q         <= pay_d;
      imag_q        <= imag_d;
    end
  end

  // record end returns to the start-of-record state
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> byte_index_q == 8'd0 && header_good_q)
    else $error("tracker not cleared after last byte");

  // text only past the header of a string record
  a_text_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.text_vld |-> byte_index_q >= HDR_BYTES && type_q == T_STRING)
    else $error("text byte outside string body");

endmodule

FILE: rtl/vrd_out_fifo.sv
`timescale 1ns / 1ps

module vrd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vrd_pkg::push_t   push_i,
  output logic             has_room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vrd_pkg::result_t out_o
);
  import vrd_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t            mem_q [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, sum_ptr;
  logic [CNT_W-1:0]   count_q, push_n;
  logic               pop;

  assign has_room_o  = count_q <= CNT_W'(OUT_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign sum_ptr     = wr_ptr_q + PTR_W'(push_i.text_vld);
  assign push_n      = CNT_W'(push_i.text_vld) + CNT_W'(push_i.sum_vld);

  always_ff @(posedge clk_i) begin
    if (push_i.text_vld) mem_q[wr_ptr_q] <= push_i.text;
    if (push_i.sum_vld)  mem_q[sum_ptr]  <= push_i.summary;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + push_n - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != '0 |-> (count_q + push_n) <= CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop && push_n == '0 |=> $stable(count_q))
    else $error("queue count moved without a transfer");

endmodule

FILE: rtl/value_record_decoder_core.sv
`timescale 1ns / 1ps

// Timing: an input byte is held in the input register stage, then folded into the
//   record state and written into the result queue, which offers it at its output.
// Throughput: one byte per cycle while the queue has room for two more entries;
//   the result queue drains one result per cycle while out_ready_i is high.
// Reset: rst_ni asynchronous, active low; clears the record state, the input
//   stage and the result queue. The block is ready right after reset.

module value_record_decoder_core #(
  parameter int STRING_CAPACITY = vrd_pkg::STRING_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  record_byte_i,
  input  logic        last_byte_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_final_o,
  output logic [2:0]  status_o,
  output logic [7:0]  value_type_o,
  output logic [63:0] payload_o,
  output logic [63:0] imag_bits_o,
  output logic [7:0]  text_byte_o,
  output logic [5:0]  text_length_o
);
  import vrd_pkg::*;

  // Input register stage. A held byte moves on to the tracker once the
  // result queue can take two more entries (text + summary worst case).
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       has_room, advance;
  push_t      push;
  result_t    res;

  assign advance    = in_vld_q && has_room;
  assign in_ready_o = !in_vld_q || has_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= record_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Record state and result formation; all combinational against the
  // registered state, so one byte per cycle while the result queue has room.
  vrd_tracker #(
    .STRING_CAPACITY(STRING_CAPACITY)
  ) u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  // Result queue: takes up to two results per cycle, hands out one per transfer.
  vrd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .has_room_o  (has_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign is_final_o    = res.is_final;
  assign status_o      = res.status;
  assign value_type_o  = res.value_type;
  assign payload_o     = res.payload;
  assign imag_bits_o   = res.imag_bits;
  assign text_byte_o   = res.text_byte;
  assign text_length_o = res.text_length;

  // input stage can only stall while it holds a byte
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q)
    else $error("input stalled while stage empty");

  // a held byte that cannot advance keeps its contents
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input stage lost a byte");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

// Byte-serial value record decoder bench: directed records from a table,
// then random records with random gaps on the byte side and random stalls
// on the result side. Results are checked against a local decoder model or a typed row.
module tb;
  import vrd_pkg::*;

  localparam int TEXT_CAP     = STRING_CAPACITY_DEF;
  localparam int ITEMS_TARGET = 450;   // input bytes over the whole run
  localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer
  localparam int TAIL_CYCLES  = 8;     // quiet time after the last result
  localparam int N_DIRECTED   = 18;

  localparam logic [23:0] MAGIC_SEQ = "QDS";  // offset 0 in the top byte
  localparam logic [2:0]  NO_FAULT  = 3'd7;   // no header byte corrupted

  // One record to send: header fields, total length, optional corruption of
  // one header byte, and for directed rows a summary status typed in by hand.
  typedef struct packed {
    logic        noise;       // every byte random
    logic        typed;       // summary taken from this row, not the model
    status_e     exp_status;
    logic [2:0]  bad_pos;     // header byte to flip, NO_FAULT for none
    logic [8:0]  n_bytes;
    logic [7:0]  kind;        // type byte at offset four
    logic [63:0] pay;         // payload word at offsets 8..15
  } rec_spec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  record_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_final_o;
  logic [2:0]  status_o;
  logic [7:0]  value_type_o;
  logic [63:0] payload_o;
  logic [63:0] imag_bits_o;
  logic [7:0]  text_byte_o;
  logic [5:0]  text_length_o;

  // Decoder model state
  logic [7:0]  dec_idx;
  logic        dec_hdr_ok;
  logic [7:0]  dec_type;
  logic [63:0] dec_pay;
  logic [63:0] dec_imag;

  result_t     expected_q[$];
  rec_spec_t   dir_table [N_DIRECTED];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  int          sink_pct = 0;

  value_record_decoder_core #(
    .STRING_CAPACITY(TEXT_CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .record_byte_i(record_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_final_o   (is_final_o),
    .status_o     (status_o),
    .value_type_o (value_type_o),
    .payload_o    (payload_o),
    .imag_bits_o  (imag_bits_o),
    .text_byte_o  (text_byte_o),
    .text_length_o(text_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------
  task automatic clear_decoder();
    dec_idx    = '0;
    dec_hdr_ok = 1'b1;
    dec_type   = '0;
    dec_pay    = '0;
    dec_imag   = '0;
  endtask

  // Fold one accepted byte into the model and queue the results it causes.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      pos;
    pos = int'(dec_idx);
    r   = '0;
    if (dec_idx < VER_POS) begin
      if (b != MAGIC_SEQ[8*(2-pos) +: 8]) dec_hdr_ok = 1'b0;
    end else if (dec_idx == VER_POS) begin
      if (b != REC_VERSION) dec_hdr_ok = 1'b0;
    end else if (dec_idx == TYPE_POS) begin
      dec_type = b;
    end else if (dec_idx >= PAY_START && dec_idx < HDR_BYTES) begin
      dec_pay[8*(pos-int'(PAY_START)) +: 8] = b;
    end else if (dec_idx >= HDR_BYTES && dec_idx < IMAG_END) begin
      dec_imag[8*(pos-int'(HDR_BYTES)) +: 8] = b;
    end

    // string characters go out as they arrive, only inside the stated length
    if (dec_hdr_ok && dec_type == T_STRING && dec_idx >= HDR_BYTES &&
        dec_pay < 64'(TEXT_CAP) && 64'(pos - int'(HDR_BYTES)) < dec_pay) begin
      r.text_byte = b;
      expected_q.push_back(r);
    end

    if (dec_idx != IDX_MAX) dec_idx++;

    if (last) begin
      r            = '0;
      r.is_final   = 1'b1;
      r.value_type = dec_type;
      if (dec_idx < HDR_BYTES) begin
        r.status = ST_SHORT;
      end else if (!dec_hdr_ok) begin
        r.status = ST_BAD_HDR;
      end else begin
        case (dec_type)
          T_EMPTY: begin
            r.status = ST_OK;
          end
          T_INT, T_FLOAT: begin
            r.payload = dec_pay;
          end
          T_COMPLEX: begin
            if (dec_idx < IMAG_END) begin
              r.status = ST_NO_IMAG;
            end else begin
              r.payload   = dec_pay;
              r.imag_bits = dec_imag;
            end
          end
          T_STRING: begin
            if (dec_pay >= 64'(TEXT_CAP)) begin
              r.status = ST_TOO_LONG;
            end else if (64'(dec_idx) < 64'(HDR_BYTES) + dec_pay) begin
              r.status = ST_OVERRUN;
            end else begin
              r.payload     = dec_pay;
              r.text_length = dec_pay[5:0];
            end
          end
          default: begin
            r.status = ST_BAD_TYPE;
          end
        endcase
      end
      expected_q.push_back(r);
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Mostly no gap, else a short one, now and then a long one.
  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 3))
      0:       return 0;   // back-to-back stretch
      3:       return 50;
      default: return 15;
    endcase
  endfunction

  function automatic logic [7:0] record_byte_at(input rec_spec_t s, input int k);
    logic [7:0] b;
    if (s.noise) b = 8'($urandom);
    else if (k < 3) b = MAGIC_SEQ[8*(2-k) +: 8];
    else if (k == int'(VER_POS)) b = REC_VERSION;
    else if (k == int'(TYPE_POS)) b = s.kind;
    else if (k >= int'(PAY_START) && k < int'(HDR_BYTES)) b = s.pay[8*(k-8) +: 8];
    else b = 8'($urandom);
    // flipping at NO_FAULT hits a reserved byte, which is random anyway
    if (k == int'(s.bad_pos)) b = b ^ 8'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic rec_spec_t random_spec();
    rec_spec_t s;
    int        sel;
    int        body;
    s         = '0;
    s.bad_pos = NO_FAULT;
    s.pay     = {$urandom, $urandom};
    sel       = $urandom_range(0, 99);
    if (sel < 10)      s.kind = T_EMPTY;
    else if (sel < 25) s.kind = T_INT;
    else if (sel < 40) s.kind = T_FLOAT;
    else if (sel < 60) s.kind = T_COMPLEX;
    else if (sel < 92) s.kind = T_STRING;
    else               s.kind = 8'($urandom_range(5, 255));

    if (s.kind == T_STRING) begin
      sel = $urandom_range(0, 99);
      if (sel < 80)      s.pay = 64'($urandom_range(0, 12));
      else if (sel < 93) s.pay = 64'($urandom_range(13, TEXT_CAP - 1));
      else if (sel < 97) s.pay = 64'($urandom_range(TEXT_CAP, TEXT_CAP + 8));
      // else keep the full random word: far too long
    end

    if (s.kind == T_COMPLEX) body = int'(IMAG_END);
    else if (s.kind == T_STRING && s.pay < 64'(TEXT_CAP))
      body = int'(HDR_BYTES) + int'(s.pay);
    else body = int'(HDR_BYTES);

    sel = $urandom_range(0, 99);
    if (sel < 8)       body = $urandom_range(1, body - 1);   // cut short
    else if (sel < 14) body = body + $urandom_range(1, 6);   // trailing junk
    if ($urandom_range(0, 99) < 8) s.bad_pos = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 5) begin
      s.noise = 1'b1;
      body    = $urandom_range(1, 40);
    end
    s.n_bytes = 9'(body);
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last, input int pace);
    int gap;
    gap = idle_len(pace);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    record_byte_i <= b;
    last_byte_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_record(input rec_spec_t s);
    int      pace;
    result_t fixed;
    pace = pick_pace();
    for (int k = 0; k < int'(s.n_bytes); k++)
      send_byte(record_byte_at(s, k), k == int'(s.n_bytes) - 1, pace);
    // Hand-typed summary replaces the modeled one; the block must still move the
    // byte from its input stage into the result queue first, so this is still in time.
    if (s.typed) begin
      fixed            = '0;
      fixed.is_final   = 1'b1;
      fixed.status     = s.exp_status;
      fixed.value_type = (s.n_bytes > 9'(TYPE_POS)) ? s.kind : 8'h00;
      void'(expected_q.pop_back());
      expected_q.push_back(fixed);
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result, final=%0b text=%02h",
                                is_final_o, text_byte_o));
    end else begin
      want = expected_q.pop_front();
      check_field("is_final", 64'(is_final_o), 64'(want.is_final));
      check_field("status", 64'(status_o), 64'(want.status));
      check_field("value_type", 64'(value_type_o), 64'(want.value_type));
      check_field("payload", payload_o, want.payload);
      check_field("imag_bits", imag_bits_o, want.imag_bits);
      check_field("text_byte", 64'(text_byte_o), 64'(want.text_byte));
      check_field("text_length", 64'(text_length_o), 64'(want.text_length));
    end
    results_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
  end

  // Result-side stalls, at a stall rate that pick_pace chooses anew during the run.
  initial begin : sink_pacing
    int hold;
    int cyc;
    hold = 0;
    cyc  = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) sink_pct = pick_pace();
      if (hold == 0) hold = idle_len(sink_pct);
      else hold--;
      out_ready_i <= (hold == 0);
    end
  end

  // Watchdog: too long without any transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    // noise typed status bad_pos n kind payload
    dir_table = '{
      '{1'b0, 1'b1, ST_SHORT,    NO_FAULT, 9'd1,   T_INT,     64'd0},
      '{1'b0, 1'b1, ST_SHORT,    NO_FAULT, 9'd5,   T_COMPLEX, 64'd0},
      '{1'b0, 1'b1, ST_SHORT,    NO_FAULT, 9'd15,  T_INT,     64'd0},
      '{1'b0, 1'b1, ST_BAD_HDR,  3'd0,     9'd16,  T_INT,     64'd7},
      '{1'b0, 1'b1, ST_BAD_HDR,  3'd3,     9'd16,  T_FLOAT,   64'd7},
      '{1'b0, 1'b1, ST_BAD_HDR,  3'd2,     9'd20,  T_STRING,  64'd4},
      '{1'b0, 1'b1, ST_BAD_TYPE, NO_FAULT, 9'd16,  8'd5,      64'd1},
      '{1'b0, 1'b1, ST_BAD_TYPE, NO_FAULT, 9'd16,  8'd255,    64'd1},
      '{1'b0, 1'b1, ST_OK,       NO_FAULT, 9'd16,  T_EMPTY,   '1},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd16,  T_INT,     '1},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd16,  T_FLOAT,   64'd0},
      '{1'b0, 1'b1, ST_NO_IMAG,  NO_FAULT, 9'd23,  T_COMPLEX, 64'd9},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd24,  T_COMPLEX, 64'h8000_0000_0000_0001},
      '{1'b0, 1'b1, ST_TOO_LONG, NO_FAULT, 9'd16,  T_STRING,  64'd64},
      '{1'b0, 1'b1, ST_OVERRUN,  NO_FAULT, 9'd20,  T_STRING,  64'd5},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd16,  T_STRING,  64'd0},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd79,  T_STRING,  64'd63},
      '{1'b0, 1'b0, ST_OK,       NO_FAULT, 9'd25,  T_STRING,  64'd3}
    };
    clear_decoder();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i]) send_record(dir_table[i]);
    while (bytes_sent < ITEMS_TARGET) send_record(random_spec());

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vrd_pkg.sv
rtl/vrd_tracker.sv
rtl/vrd_out_fifo.sv
rtl/value_record_decoder_core.sv
sim/tb.sv
